/* design/link_ip_transport_header_parser_core_defines.svh */
// Assertion helpers for the link/IP/transport header parser.
`ifndef LINK_IP_TRANSPORT_HEADER_PARSER_CORE_DEFINES_SVH
`define LINK_IP_TRANSPORT_HEADER_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define LITP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define LITP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/litp_pkg.sv */
package litp_pkg;

  localparam int unsigned MAX_PACKET_BYTES = 65535;
  localparam int unsigned IDX_W = 16;   // byte counter
  localparam int unsigned HDR_W = 8;    // header end, at most 14 + 60 + 60

  // frame types
  localparam logic [15:0] ETH_IPV4  = 16'h0800;
  localparam logic [15:0] PPP_IPV4  = 16'h0001;
  localparam logic [15:0] ETH_NDN   = 16'h7777;
  localparam logic [15:0] ETH_NDNLP = 16'h8624;
  localparam logic [15:0] PPP_NDN   = 16'h0077;

  localparam logic [7:0] IP_PROTO_UDP = 8'd17;
  localparam logic [7:0] IP_PROTO_TCP = 8'd6;

  localparam logic [5:0]       MIN_HDR_BYTES  = 6'd20;
  localparam logic [HDR_W-1:0] ETH_HDR_BYTES  = HDR_W'(14);
  localparam logic [HDR_W-1:0] UDP_HDR_BYTES  = HDR_W'(8);
  localparam logic [HDR_W-1:0] PPP_SHIM_BYTES = HDR_W'(2);

  // byte positions
  localparam logic [IDX_W-1:0] ETH_TYPE_HI  = IDX_W'(12);
  localparam logic [IDX_W-1:0] ETH_TYPE_LO  = IDX_W'(13);
  localparam logic [IDX_W-1:0] IP_PROTO_POS = IDX_W'(9);
  localparam logic [IDX_W-1:0] IP_SRC_FIRST = IDX_W'(12);
  localparam logic [IDX_W-1:0] IP_SRC_LAST  = IDX_W'(15);
  localparam logic [IDX_W-1:0] IP_DST_FIRST = IDX_W'(16);
  localparam logic [IDX_W-1:0] IP_DST_LAST  = IDX_W'(19);
  localparam logic [IDX_W-1:0] TCP_DOFF_POS = IDX_W'(12);

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  typedef enum logic [4:0] {
    PH_LINK = 5'b00001,
    PH_IP   = 5'b00010,
    PH_TCP  = 5'b00100,
    PH_DONE = 5'b01000,
    PH_ERR  = 5'b10000
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_TRUNC       = 3'd1,
    ST_BAD_FRAME   = 3'd2,
    ST_BAD_IP_LEN  = 3'd3,
    ST_BAD_TCP_LEN = 3'd4,
    ST_BAD_PROTO   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    TUN_UDP       = 3'd0,
    TUN_TCP       = 3'd1,
    TUN_ETH_NDN   = 3'd2,
    TUN_ETH_NDNLP = 3'd3,
    TUN_PPP       = 3'd4
  } tunnel_e;

  // Per-packet parse state; also the record handed to the back end.
  typedef struct packed {
    phase_e           phase;
    status_e          err;
    tunnel_e          tun;
    logic [15:0]      frame;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [HDR_W-1:0] hdr_end;
    logic [IDX_W-1:0] byte_cnt;
  } parse_rec_t;

  localparam parse_rec_t REC_RESET = '{
    phase:    PH_LINK,
    err:      ST_OK,
    tun:      TUN_UDP,
    frame:    16'h0000,
    src:      32'h0,
    dst:      32'h0,
    hdr_end:  '0,
    byte_cnt: '0
  };

endpackage

/* design/link_ip_transport_header_parser_core.sv */
// Link / IPv4 / transport header parser.
// Input channel (in_valid_i/in_ready_o): one packet byte per item, with
// first_byte_i restarting a packet and last_byte_i closing it. A byte
// stream that starts without first_byte_i is taken as a new packet.
// Output channel (out_valid_o/out_ready_i): one result item per packet,
// given for the item that carries last_byte_i: status, tunnel kind, frame
// type, IPv4 addresses, payload offset and payload length.
// Config: cfg_we_i writes cfg_wdata_i into the link type (0 Ethernet,
// 1 PPP); write it only between packets.
// Throughput: one byte per cycle while the queue is not full (in_ready_o
// high). The front parser updates its state on each accepted byte; results
// go through a two-entry queue to the output register: a result is held in
// a queue slot, then moves into the output register once that is free.
// Stall: while the receiver holds out_ready_i low, bytes keep flowing until
// two further results are queued; then in_ready_o drops.
// Reset (rst_ni, async, active low): link type goes to Ethernet, parse
// state, queue and output valid are cleared; no memory sweep is needed.
`include "link_ip_transport_header_parser_core_defines.svh"

module link_ip_transport_header_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [2:0]  tunnel_kind_o,
  output logic [15:0] frame_kind_o,
  output logic [31:0] source_address_o,
  output logic [31:0] dest_address_o,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_length_o
);

  // front -> queue
  logic                 push;
  logic                 q_full;
  litp_pkg::parse_rec_t push_rec;

  // queue -> back
  logic                 q_valid;
  logic                 pop;
  litp_pkg::parse_rec_t head_rec;

  // Front: per-byte parse, one record per packet on the last byte.
  litp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  // Decouples the parser from a stalled receiver.
  litp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .rec_i   (push_rec),
    .full_o  (q_full),
    .valid_o (q_valid),
    .rec_o   (head_rec),
    .pop_i   (pop)
  );

  // Back: status decision, field masking, payload length, output register.
  litp_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .rec_valid_i      (q_valid),
    .rec_i            (head_rec),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .tunnel_kind_o    (tunnel_kind_o),
    .frame_kind_o     (frame_kind_o),
    .source_address_o (source_address_o),
    .dest_address_o   (dest_address_o),
    .payload_offset_o (payload_offset_o),
    .payload_length_o (payload_length_o)
  );

  // Failed parse: only status and frame type carry information.
  `LITP_ASSERT_IMPLIES(a_err_fields_zero,
    out_valid_o && status_o != litp_pkg::ST_OK,
    tunnel_kind_o == 3'd0 && source_address_o == 32'h0 && dest_address_o == 32'h0 &&
    payload_offset_o == 16'h0 && payload_length_o == 16'h0,
    "error result carries nonzero fields")

  // UDP/TCP tunnels only come out of an IPv4 frame.
  `LITP_ASSERT_IMPLIES(a_transport_is_ip,
    out_valid_o && status_o == litp_pkg::ST_OK &&
    (tunnel_kind_o == litp_pkg::TUN_UDP || tunnel_kind_o == litp_pkg::TUN_TCP),
    frame_kind_o == litp_pkg::ETH_IPV4 || frame_kind_o == litp_pkg::PPP_IPV4,
    "transport tunnel on a non-IP frame")

  // A closed packet reaches the output through the queue and the output register.
  `LITP_ASSERT_NEXT(a_result_follows,
    in_valid_i && in_ready_o && last_byte_i,
    ##1 out_valid_o,
    "result missing after last byte")

endmodule

/* design/litp_front.sv */
module litp_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  first_byte_i,
  input  logic                  last_byte_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output litp_pkg::parse_rec_t  rec_o
);

  logic                 link_type_q;
  litp_pkg::parse_rec_t st_q, cur, nxt;
  logic [5:0]           ihb_q, ihb_cur, ihb_d;
  logic [7:0]           proto_q, proto_cur, proto_d;
  logic [litp_pkg::IDX_W-1:0] k;
  logic [5:0]           doff;
  logic                 fire;

  // Link header done at offset base: pick the next phase from the frame type.
  function automatic litp_pkg::parse_rec_t dispatch(litp_pkg::parse_rec_t s,
                                                    logic [litp_pkg::HDR_W-1:0] base);
    litp_pkg::parse_rec_t r;
    r = s;
    r.hdr_end = base;
    if (r.frame == litp_pkg::ETH_IPV4 || r.frame == litp_pkg::PPP_IPV4) begin
      r.phase = litp_pkg::PH_IP;
    end else if (r.frame == litp_pkg::ETH_NDN) begin
      r.tun   = litp_pkg::TUN_ETH_NDN;
      r.phase = litp_pkg::PH_DONE;
    end else if (r.frame == litp_pkg::ETH_NDNLP) begin
      r.tun   = litp_pkg::TUN_ETH_NDNLP;
      r.phase = litp_pkg::PH_DONE;
    end else if (r.frame == litp_pkg::PPP_NDN) begin
      r.tun     = litp_pkg::TUN_PPP;
      r.hdr_end = base + litp_pkg::PPP_SHIM_BYTES;
      r.phase   = litp_pkg::PH_DONE;
    end else begin
      r.err   = litp_pkg::ST_BAD_FRAME;
      r.phase = litp_pkg::PH_ERR;
    end
    return r;
  endfunction

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign push_o     = fire && last_byte_i;
  assign rec_o      = nxt;

  always_comb begin
    cur       = first_byte_i ? litp_pkg::REC_RESET : st_q;
    ihb_cur   = first_byte_i ? 6'd0 : ihb_q;
    proto_cur = first_byte_i ? 8'd0 : proto_q;
    nxt       = cur;
    ihb_d     = ihb_cur;
    proto_d   = proto_cur;
    k         = cur.byte_cnt - litp_pkg::IDX_W'(cur.hdr_end);
    doff      = {data_byte_i[7:4], 2'b00};
    if (cur.byte_cnt != litp_pkg::IDX_W'(litp_pkg::MAX_PACKET_BYTES)) begin
      nxt.byte_cnt = cur.byte_cnt + litp_pkg::IDX_W'(1);
      case (cur.phase)
        litp_pkg::PH_LINK: begin
          if (!link_type_q) begin
            if (cur.byte_cnt == litp_pkg::ETH_TYPE_HI) begin
              nxt.frame = {data_byte_i, 8'h00};
            end else if (cur.byte_cnt == litp_pkg::ETH_TYPE_LO) begin
              nxt.frame = cur.frame | {8'h00, data_byte_i};
              nxt       = dispatch(nxt, litp_pkg::ETH_HDR_BYTES);
            end
          end else begin
            if (cur.byte_cnt == litp_pkg::IDX_W'(0)) begin
              nxt.frame = {8'h00, data_byte_i};
              if (data_byte_i[0]) begin
                nxt = dispatch(nxt, litp_pkg::HDR_W'(1));
              end
            end else if (cur.byte_cnt == litp_pkg::IDX_W'(1)) begin
              nxt.frame = {cur.frame[7:0], data_byte_i};
              nxt       = dispatch(nxt, litp_pkg::HDR_W'(2));
            end
          end
        end
        litp_pkg::PH_IP: begin
          if (k == litp_pkg::IDX_W'(0)) begin
            ihb_d = {data_byte_i[3:0], 2'b00};
            if (ihb_d < litp_pkg::MIN_HDR_BYTES) begin
              nxt.err   = litp_pkg::ST_BAD_IP_LEN;
              nxt.phase = litp_pkg::PH_ERR;
            end
          end else begin
            if (k == litp_pkg::IP_PROTO_POS) begin
              proto_d = data_byte_i;
            end else if (k inside {[litp_pkg::IP_SRC_FIRST:litp_pkg::IP_SRC_LAST]}) begin
              nxt.src = {cur.src[23:0], data_byte_i};
            end else if (k inside {[litp_pkg::IP_DST_FIRST:litp_pkg::IP_DST_LAST]}) begin
              nxt.dst = {cur.dst[23:0], data_byte_i};
            end
            if (k + litp_pkg::IDX_W'(1) == litp_pkg::IDX_W'(ihb_cur)) begin
              nxt.hdr_end = cur.hdr_end + litp_pkg::HDR_W'(ihb_cur);
              if (proto_d == litp_pkg::IP_PROTO_UDP) begin
                nxt.tun     = litp_pkg::TUN_UDP;
                nxt.hdr_end = cur.hdr_end + litp_pkg::HDR_W'(ihb_cur)
                              + litp_pkg::UDP_HDR_BYTES;
                nxt.phase   = litp_pkg::PH_DONE;
              end else if (proto_d == litp_pkg::IP_PROTO_TCP) begin
                nxt.tun   = litp_pkg::TUN_TCP;
                nxt.phase = litp_pkg::PH_TCP;
              end else begin
                nxt.err   = litp_pkg::ST_BAD_PROTO;
                nxt.phase = litp_pkg::PH_ERR;
              end
            end
          end
        end
        litp_pkg::PH_TCP: begin
          if (k == litp_pkg::TCP_DOFF_POS) begin
            if (doff < litp_pkg::MIN_HDR_BYTES) begin
              nxt.err   = litp_pkg::ST_BAD_TCP_LEN;
              nxt.phase = litp_pkg::PH_ERR;
            end else begin
              nxt.hdr_end = cur.hdr_end + litp_pkg::HDR_W'(doff);
              nxt.phase   = litp_pkg::PH_DONE;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      link_type_q <= 1'b0;
      st_q        <= litp_pkg::REC_RESET;
      ihb_q       <= 6'd0;
      proto_q     <= 8'd0;
    end else begin
      if (cfg_we_i) begin
        link_type_q <= cfg_wdata_i;
      end
      if (fire) begin
        if (last_byte_i) begin
          st_q    <= litp_pkg::REC_RESET;
          ihb_q   <= 6'd0;
          proto_q <= 8'd0;
        end else begin
          st_q    <= nxt;
          ihb_q   <= ihb_d;
          proto_q <= proto_d;
        end
      end
    end
  end

endmodule

/* design/litp_queue.sv */
module litp_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  litp_pkg::parse_rec_t  rec_i,
  output logic                  full_o,
  output logic                  valid_o,
  output litp_pkg::parse_rec_t  rec_o,
  input  logic                  pop_i
);

  litp_pkg::parse_rec_t       slot_q [litp_pkg::QUEUE_DEPTH];
  logic [litp_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [litp_pkg::QPTR_W:0]   count_q;

  assign full_o  = count_q == (litp_pkg::QPTR_W+1)'(litp_pkg::QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign rec_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + litp_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + litp_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (litp_pkg::QPTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (litp_pkg::QPTR_W+1)'(1);
      end
    end
  end

endmodule

/* design/litp_back.sv */
module litp_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  rec_valid_i,
  input  litp_pkg::parse_rec_t  rec_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [2:0]            status_o,
  output logic [2:0]            tunnel_kind_o,
  output logic [15:0]           frame_kind_o,
  output logic [31:0]           source_address_o,
  output logic [31:0]           dest_address_o,
  output logic [15:0]           payload_offset_o,
  output logic [15:0]           payload_length_o
);

  logic                      out_valid_q;
  logic                      slot_free;
  litp_pkg::status_e         status_d;
  logic                      is_ip;
  logic [litp_pkg::IDX_W-1:0] hdr_end_w;
  logic [2:0]  tunnel_d;
  logic [31:0] src_d, dst_d;
  logic [15:0] off_d, len_d;
  logic [2:0]  status_q, tunnel_q;
  logic [15:0] frame_q, off_q, len_q;
  logic [31:0] src_q, dst_q;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign pop_o       = rec_valid_i && slot_free;
  assign out_valid_o = out_valid_q;

  always_comb begin
    hdr_end_w = litp_pkg::IDX_W'(rec_i.hdr_end);
    is_ip     = rec_i.frame == litp_pkg::ETH_IPV4 || rec_i.frame == litp_pkg::PPP_IPV4;
    if (rec_i.phase == litp_pkg::PH_ERR) begin
      status_d = rec_i.err;
    end else if (rec_i.phase != litp_pkg::PH_DONE || rec_i.byte_cnt < hdr_end_w) begin
      status_d = litp_pkg::ST_TRUNC;
    end else begin
      status_d = litp_pkg::ST_OK;
    end
    tunnel_d = 3'd0;
    src_d    = 32'h0;
    dst_d    = 32'h0;
    off_d    = 16'h0;
    len_d    = 16'h0;
    if (status_d == litp_pkg::ST_OK) begin
      tunnel_d = rec_i.tun;
      src_d    = is_ip ? rec_i.src : 32'h0;
      dst_d    = is_ip ? rec_i.dst : 32'h0;
      off_d    = hdr_end_w;
      len_d    = rec_i.byte_cnt - hdr_end_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= rec_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q <= status_d;
      tunnel_q <= tunnel_d;
      frame_q  <= rec_i.frame;
      src_q    <= src_d;
      dst_q    <= dst_d;
      off_q    <= off_d;
      len_q    <= len_d;
    end
  end

  assign status_o         = status_q;
  assign tunnel_kind_o    = tunnel_q;
  assign frame_kind_o     = frame_q;
  assign source_address_o = src_q;
  assign dest_address_o   = dst_q;
  assign payload_offset_o = off_q;
  assign payload_length_o = len_q;

endmodule
